// ----- rtl/tawlf_pkg.sv -----
// ----------------------------------------------------------------------------
// tawlf_pkg
// Shared types, character codes, error codes and the mnemonic table.
// ----------------------------------------------------------------------------
package tawlf_pkg;

    // classified source word, front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       is_ws;
        logic       is_dec;
        logic       is_hex;
        logic       is_bin;
        logic [3:0] dval;
    } t_item;

    // one result word
    typedef struct packed {
        logic        we;
        logic [12:0] addr;
        logic [15:0] data;
        logic [2:0]  err;
        logic [4:0]  slot;
        logic        last;
    } t_res;

    localparam int QDEPTH      = 4;
    localparam int QPW         = 2;
    localparam int MAX_RESULTS = 32;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_MNEM    = 3'd1;
    localparam logic [2:0] ERR_REDEF   = 3'd2;
    localparam logic [2:0] ERR_REFS    = 3'd3;
    localparam logic [2:0] ERR_FULL    = 3'd4;
    localparam logic [2:0] ERR_UNBOUND = 3'd5;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [15:0] MN_BAD  = 16'hfffc;
    localparam logic [11:0] MN_BASE = 12'hfff;

    localparam logic [23:0] OP_TABLE [16] = '{
        "jmp", "cnd", "get", "set", "and", "ior", "xor", "sft",
        "add", "sub", "swp", "out", "idk", "idc", "pop", "psh"
    };

    // {hit, opcode}; lowest matching entry wins
    function automatic logic [4:0] mn_lookup(input logic [23:0] key);
        logic [4:0] r;
        r = 5'd0;
        for (int k = 15; k >= 0; k--) begin
            if (OP_TABLE[k] == key) r = {1'b1, 4'(k)};
        end
        return r;
    endfunction

endpackage

// ----- rtl/tawlf_ram.sv -----
// ----------------------------------------------------------------------------
// tawlf_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module tawlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- rtl/tawlf_front.sv -----
// ----------------------------------------------------------------------------
// tawlf_front
// Accepts source words, classifies each character and queues it for the back.
// ----------------------------------------------------------------------------
module tawlf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_char_code,
    input  logic                  i_end_of_input,
    output logic                  o_valid,
    input  logic                  i_take,
    output tawlf_pkg::t_item      o_item
);

    tawlf_pkg::t_item                 r_q [tawlf_pkg::QDEPTH];
    logic [tawlf_pkg::QPW-1:0]        r_wp;
    logic [tawlf_pkg::QPW-1:0]        r_rp;
    logic [tawlf_pkg::QPW:0]          r_cnt;
    tawlf_pkg::t_item                 cls;
    logic                             do_push;
    logic                             do_pop;

    // character classes
    always_comb begin
        cls.ch     = i_char_code;
        cls.eoi    = i_end_of_input;
        cls.is_ws  = (i_char_code == tawlf_pkg::CH_SPACE) || (i_char_code == tawlf_pkg::CH_NL)
                     || (i_char_code == tawlf_pkg::CH_TAB);
        cls.is_dec = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
        cls.is_hex = (i_char_code >= 8'h61) && (i_char_code <= 8'h66);
        cls.is_bin = (i_char_code == 8'h30) || (i_char_code == 8'h31);
        cls.dval   = cls.is_hex ? 4'(i_char_code[3:0] + 4'd9) : i_char_code[3:0];
    end

    assign full    = (r_cnt == (tawlf_pkg::QPW+1)'(tawlf_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign do_push = push && !full;
    assign do_pop  = i_take && o_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= cls;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/tawlf_back.sv -----
// ----------------------------------------------------------------------------
// tawlf_back
// Token sequencer: numbers, strings, mnemonics, label table, fixups, report.
// ----------------------------------------------------------------------------
module tawlf_back #(
    parameter int MEM_WORDS  = 8192,
    parameter int NAME_LEN   = 32,
    parameter int NUM_LABELS = 32,
    parameter int MAX_REFS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_take,
    input  tawlf_pkg::t_item      i_item,
    output logic                  o_empty,
    input  logic                  i_pop,
    output tawlf_pkg::t_res       o_res
);

    localparam int AW  = $clog2(MEM_WORDS);
    localparam int NW  = $clog2(NAME_LEN);
    localparam int SW  = $clog2(NUM_LABELS);
    localparam int LW  = SW + 1;
    localparam int RW  = $clog2(MAX_REFS + 1);
    localparam int RI  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int OCW = $clog2(tawlf_pkg::MAX_RESULTS + 1);

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_NUMSTART, M_NUM, M_STRING, M_DEF, M_REF, M_MN1, M_MN2, M_DONE
    } t_mode;

    typedef enum logic [1:0] {R_DEC, R_HEX, R_BIN} t_radix;

    typedef enum logic [4:0] {
        S_FETCH, S_EXEC, S_EMIT, S_END,
        S_LK_SLOT, S_LK_LEN, S_LK_CHR, S_LK_CMP, S_FD,
        S_FX_RD, S_FX_PUT, S_CP_RD, S_CP_WR, S_NEW_FIN,
        S_REP_RD, S_REP_CHK
    } t_state;

    t_state            r_state, r_ret, r_fin;
    t_mode             r_mode;
    t_radix            r_radix;
    tawlf_pkg::t_item  r_it;
    logic [15:0]       r_acc;
    logic [AW-1:0]     r_addr;
    logic [NW-1:0]     r_tlen, r_nul_pos, r_len, r_i;
    logic              r_nul_seen, r_ref;
    logic [7:0]        r_m0, r_m1;
    logic [LW-1:0]     r_lcount, r_s, r_cur;
    logic [RW-1:0]     r_j, r_cnt;
    logic [OCW-1:0]    r_ocnt;

    // pending emit
    logic              r_e_we;
    logic [15:0]       r_e_data;
    logic [2:0]        r_e_err;
    logic [4:0]        r_e_slot;

    // result holding and output stages
    tawlf_pkg::t_res   r_pend, r_out;
    logic              r_pend_v, r_out_v;

    // registered RAM write ports
    logic              r_tok_we, r_nm_we, r_len_we, r_val_we, r_rc_we, r_fx_we;
    logic [NW-1:0]     r_tok_wa;
    logic [7:0]        r_tok_wd, r_nm_wd;
    logic [SW+NW-1:0]  r_nm_wa;
    logic [SW-1:0]     r_lab_wa;
    logic [NW-1:0]     r_len_wd;
    logic [15:0]       r_val_wd;
    logic [RW-1:0]     r_rc_wd;
    logic [SW+RI-1:0]  r_fx_wa;
    logic [AW-1:0]     r_fx_wd;

    // RAM read side
    logic [7:0]        tok_q, nm_q;
    logic [NW-1:0]     len_q;
    logic [15:0]       val_q;
    logic [RW-1:0]     rc_q;
    logic [AW-1:0]     fx_q;
    logic [SW-1:0]     lab_ra;

    // combinational helpers
    logic [AW-1:0]     addr_inc;
    logic [15:0]       here;
    logic [NW-1:0]     nm_len;
    logic [7:0]        k1, k2;
    logic [4:0]        mn;
    logic [15:0]       mn_data;
    logic [2:0]        mn_err;
    logic              is_digit;
    logic [15:0]       acc_next;
    logic              out_free, can_put, put_req, put_go;
    tawlf_pkg::t_res   put_res;

    // label table and token stores
    tawlf_ram #(.WIDTH(8), .DEPTH(NAME_LEN)) u_tok (
        .i_clk(i_clk), .i_we(r_tok_we), .i_waddr(r_tok_wa), .i_wdata(r_tok_wd),
        .i_raddr(r_i), .o_rdata(tok_q));

    tawlf_ram #(.WIDTH(8), .DEPTH(NUM_LABELS * (2 ** NW))) u_name (
        .i_clk(i_clk), .i_we(r_nm_we), .i_waddr(r_nm_wa), .i_wdata(r_nm_wd),
        .i_raddr({r_s[SW-1:0], r_i}), .o_rdata(nm_q));

    tawlf_ram #(.WIDTH(NW), .DEPTH(NUM_LABELS)) u_nlen (
        .i_clk(i_clk), .i_we(r_len_we), .i_waddr(r_lab_wa), .i_wdata(r_len_wd),
        .i_raddr(r_s[SW-1:0]), .o_rdata(len_q));

    tawlf_ram #(.WIDTH(16), .DEPTH(NUM_LABELS)) u_val (
        .i_clk(i_clk), .i_we(r_val_we), .i_waddr(r_lab_wa), .i_wdata(r_val_wd),
        .i_raddr(lab_ra), .o_rdata(val_q));

    tawlf_ram #(.WIDTH(RW), .DEPTH(NUM_LABELS)) u_rcnt (
        .i_clk(i_clk), .i_we(r_rc_we), .i_waddr(r_lab_wa), .i_wdata(r_rc_wd),
        .i_raddr(r_s[SW-1:0]), .o_rdata(rc_q));

    tawlf_ram #(.WIDTH(AW), .DEPTH(NUM_LABELS * (2 ** RI))) u_fix (
        .i_clk(i_clk), .i_we(r_fx_we), .i_waddr(r_fx_wa), .i_wdata(r_fx_wd),
        .i_raddr({r_s[SW-1:0], r_j[RI-1:0]}), .o_rdata(fx_q));

    assign lab_ra = (r_state == S_REP_RD || r_state == S_REP_CHK) ? r_cur[SW-1:0]
                                                                   : r_s[SW-1:0];

    // address and token helpers
    assign addr_inc = (r_addr == AW'(MEM_WORDS - 1)) ? '0 : r_addr + 1'b1;
    assign here     = 16'(r_addr);
    assign nm_len   = r_nul_seen ? r_nul_pos : r_tlen;

    // mnemonic decode; missing characters read as NUL at end of input
    assign k1      = (r_mode == M_MN1) ? tawlf_pkg::CH_NUL : r_m1;
    assign k2      = r_it.eoi ? tawlf_pkg::CH_NUL : r_it.ch;
    assign mn      = tawlf_pkg::mn_lookup({r_m0, k1, k2});
    assign mn_data = mn[4] ? {tawlf_pkg::MN_BASE, mn[3:0]} : tawlf_pkg::MN_BAD;
    assign mn_err  = mn[4] ? tawlf_pkg::ERR_NONE : tawlf_pkg::ERR_MNEM;

    // digit accumulate
    always_comb begin
        case (r_radix)
            R_HEX: begin
                is_digit = r_it.is_dec || r_it.is_hex;
                acc_next = {r_acc[11:0], r_it.dval};
            end
            R_BIN: begin
                is_digit = r_it.is_bin;
                acc_next = {r_acc[14:0], r_it.dval[0]};
            end
            default: begin
                is_digit = r_it.is_dec;
                acc_next = {r_acc[12:0], 3'b000} + {r_acc[14:0], 1'b0} + 16'(r_it.dval);
            end
        endcase
    end

    // result request from the sequencer
    always_comb begin
        put_req = 1'b0;
        put_res = '0;
        case (r_state)
            S_EMIT: begin
                put_req      = 1'b1;
                put_res.we   = r_e_we;
                put_res.addr = 13'(r_addr);
                put_res.data = r_e_data;
                put_res.err  = r_e_err;
                put_res.slot = r_e_slot;
            end
            S_FX_PUT: begin
                put_req      = 1'b1;
                put_res.we   = 1'b1;
                put_res.addr = 13'(fx_q);
                put_res.data = here;
            end
            S_REP_CHK: begin
                put_req      = (val_q == 16'd0);
                put_res.addr = 13'(r_addr);
                put_res.err  = tawlf_pkg::ERR_UNBOUND;
                put_res.slot = 5'(r_cur);
            end
            default: put_req = 1'b0;
        endcase
    end

    assign out_free = !r_out_v || i_pop;
    assign can_put  = !r_pend_v || out_free;
    assign put_go   = put_req && can_put;
    assign o_take   = (r_state == S_FETCH) && i_valid;
    assign o_empty  = !r_out_v;
    assign o_res    = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FETCH;
            r_ret      <= S_END;
            r_fin      <= S_END;
            r_mode     <= M_IDLE;
            r_radix    <= R_DEC;
            r_acc      <= '0;
            r_addr     <= '0;
            r_tlen     <= '0;
            r_nul_seen <= 1'b0;
            r_lcount   <= '0;
            r_cur      <= '0;
            r_ocnt     <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_tok_we   <= 1'b0;
            r_nm_we    <= 1'b0;
            r_len_we   <= 1'b0;
            r_val_we   <= 1'b0;
            r_rc_we    <= 1'b0;
            r_fx_we    <= 1'b0;
        end else begin
            r_tok_we <= 1'b0;
            r_nm_we  <= 1'b0;
            r_len_we <= 1'b0;
            r_val_we <= 1'b0;
            r_rc_we  <= 1'b0;
            r_fx_we  <= 1'b0;

            if (i_pop && r_out_v) r_out_v <= 1'b0;

            // hold one result back so that the last one can be marked
            if (put_go) begin
                if (r_pend_v) begin
                    r_out   <= r_pend;
                    r_out_v <= 1'b1;
                end
                r_pend   <= put_res;
                r_pend_v <= 1'b1;
                r_ocnt   <= r_ocnt + 1'b1;
            end

            case (r_state)
                S_FETCH: begin
                    if (i_valid) begin
                        r_it    <= i_item;
                        r_ocnt  <= '0;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (r_mode == M_DONE) begin
                        r_state <= r_it.eoi ? S_REP_RD : S_END;
                    end else if (r_it.eoi || (r_mode == M_IDLE && r_it.ch == tawlf_pkg::CH_NUL))
                    begin
                        // end of source: close the open token, then report
                        r_mode <= M_DONE;
                        r_cur  <= '0;
                        r_fin  <= S_REP_RD;
                        r_ret  <= S_REP_RD;
                        case (r_mode)
                            M_NUMSTART, M_NUM: begin
                                r_e_we   <= 1'b1;
                                r_e_data <= r_acc;
                                r_e_err  <= tawlf_pkg::ERR_NONE;
                                r_e_slot <= '0;
                                r_state  <= S_EMIT;
                            end
                            M_DEF, M_REF: begin
                                r_ref   <= (r_mode == M_REF);
                                r_len   <= nm_len;
                                r_s     <= '0;
                                r_state <= S_LK_SLOT;
                            end
                            M_MN1, M_MN2: begin
                                r_e_we   <= 1'b1;
                                r_e_data <= mn_data;
                                r_e_err  <= mn_err;
                                r_e_slot <= '0;
                                r_state  <= S_EMIT;
                            end
                            default: r_state <= S_REP_RD;
                        endcase
                    end else begin
                        r_fin   <= S_END;
                        r_ret   <= S_END;
                        r_state <= S_END;
                        case (r_mode)
                            M_IDLE: begin
                                if (!r_it.is_ws) begin
                                    case (r_it.ch)
                                        tawlf_pkg::CH_SEMI: r_mode <= M_COMMENT;
                                        tawlf_pkg::CH_QUOTE: begin
                                            r_acc  <= '0;
                                            r_mode <= M_NUMSTART;
                                        end
                                        tawlf_pkg::CH_DQ: r_mode <= M_STRING;
                                        tawlf_pkg::CH_COLON, tawlf_pkg::CH_DOT: begin
                                            r_tlen     <= '0;
                                            r_nul_seen <= 1'b0;
                                            r_mode     <= (r_it.ch == tawlf_pkg::CH_DOT) ? M_REF
                                                                                         : M_DEF;
                                        end
                                        default: begin
                                            r_m0   <= r_it.ch;
                                            r_mode <= M_MN1;
                                        end
                                    endcase
                                end
                            end
                            M_COMMENT: begin
                                if (r_it.ch == tawlf_pkg::CH_NL) r_mode <= M_IDLE;
                            end
                            M_NUMSTART: begin
                                if (r_it.ch == tawlf_pkg::CH_X) begin
                                    r_radix <= R_HEX;
                                    r_mode  <= M_NUM;
                                end else if (r_it.ch == tawlf_pkg::CH_B) begin
                                    r_radix <= R_BIN;
                                    r_mode  <= M_NUM;
                                end else begin
                                    r_radix <= R_DEC;
                                    if (r_it.is_dec) begin
                                        r_acc  <= 16'(r_it.dval);
                                        r_mode <= M_NUM;
                                    end else begin
                                        r_e_we   <= 1'b1;
                                        r_e_data <= r_acc;
                                        r_e_err  <= tawlf_pkg::ERR_NONE;
                                        r_e_slot <= '0;
                                        r_mode   <= M_IDLE;
                                        r_state  <= S_EMIT;
                                    end
                                end
                            end
                            M_NUM: begin
                                if (is_digit) begin
                                    r_acc <= acc_next;
                                end else begin
                                    r_e_we   <= 1'b1;
                                    r_e_data <= r_acc;
                                    r_e_err  <= tawlf_pkg::ERR_NONE;
                                    r_e_slot <= '0;
                                    r_mode   <= M_IDLE;
                                    r_state  <= S_EMIT;
                                end
                            end
                            M_STRING: begin
                                if (r_it.ch == tawlf_pkg::CH_DQ) begin
                                    r_mode <= M_IDLE;
                                end else begin
                                    r_e_we   <= 1'b1;
                                    r_e_data <= {8'd0, r_it.ch};
                                    r_e_err  <= tawlf_pkg::ERR_NONE;
                                    r_e_slot <= '0;
                                    r_state  <= S_EMIT;
                                end
                            end
                            M_DEF, M_REF: begin
                                if (r_it.is_ws) begin
                                    r_ref   <= (r_mode == M_REF);
                                    r_len   <= nm_len;
                                    r_s     <= '0;
                                    r_mode  <= M_IDLE;
                                    r_state <= S_LK_SLOT;
                                end else if (r_tlen < NW'(NAME_LEN - 1)) begin
                                    r_tok_we <= 1'b1;
                                    r_tok_wa <= r_tlen;
                                    r_tok_wd <= r_it.ch;
                                    if (r_it.ch == tawlf_pkg::CH_NUL && !r_nul_seen) begin
                                        r_nul_seen <= 1'b1;
                                        r_nul_pos  <= r_tlen;
                                    end
                                    r_tlen <= r_tlen + 1'b1;
                                end
                            end
                            M_MN1: begin
                                r_m1   <= r_it.ch;
                                r_mode <= M_MN2;
                            end
                            M_MN2: begin
                                r_e_we   <= 1'b1;
                                r_e_data <= mn_data;
                                r_e_err  <= mn_err;
                                r_e_slot <= '0;
                                r_mode   <= M_IDLE;
                                r_state  <= S_EMIT;
                            end
                            default: r_mode <= M_IDLE;
                        endcase
                    end
                end

                S_EMIT: begin
                    if (can_put) begin
                        if (r_e_we) r_addr <= addr_inc;
                        r_state <= r_ret;
                    end
                end

                // label search, one slot and one character at a time
                S_LK_SLOT: begin
                    if (r_s == r_lcount) begin
                        if (r_lcount == LW'(NUM_LABELS)) begin
                            r_e_we   <= r_ref;
                            r_e_data <= '0;
                            r_e_err  <= tawlf_pkg::ERR_FULL;
                            r_e_slot <= '0;
                            r_ret    <= r_fin;
                            r_state  <= S_EMIT;
                        end else begin
                            r_i     <= '0;
                            r_state <= S_CP_RD;
                        end
                    end else begin
                        r_state <= S_LK_LEN;
                    end
                end
                S_LK_LEN: begin
                    if (len_q == r_len) begin
                        r_i     <= '0;
                        r_state <= S_LK_CHR;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_LK_SLOT;
                    end
                end
                S_LK_CHR: begin
                    r_state <= (r_i == r_len) ? S_FD : S_LK_CMP;
                end
                S_LK_CMP: begin
                    if (nm_q == tok_q) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_LK_CHR;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_LK_SLOT;
                    end
                end

                // label found
                S_FD: begin
                    r_e_data <= '0;
                    r_e_err  <= tawlf_pkg::ERR_NONE;
                    r_e_slot <= '0;
                    r_ret    <= r_fin;
                    if (!r_ref) begin
                        r_cnt <= rc_q;
                        r_j   <= '0;
                        if (val_q != 16'd0) begin
                            r_e_we   <= 1'b0;
                            r_e_err  <= tawlf_pkg::ERR_REDEF;
                            r_e_slot <= 5'(r_s);
                            r_ret    <= S_FX_RD;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_FX_RD;
                        end
                    end else begin
                        r_e_we  <= 1'b1;
                        r_state <= S_EMIT;
                        if (val_q != 16'd0) begin
                            r_e_data <= val_q;
                        end else if (rc_q >= RW'(MAX_REFS)) begin
                            r_e_err  <= tawlf_pkg::ERR_REFS;
                            r_e_slot <= 5'(r_s);
                        end else begin
                            r_fx_we  <= 1'b1;
                            r_fx_wa  <= {r_s[SW-1:0], rc_q[RI-1:0]};
                            r_fx_wd  <= r_addr;
                            r_rc_we  <= 1'b1;
                            r_lab_wa <= r_s[SW-1:0];
                            r_rc_wd  <= rc_q + 1'b1;
                        end
                    end
                end

                // patch recorded references, then bind
                S_FX_RD: begin
                    if (r_j == r_cnt) begin
                        r_val_we <= 1'b1;
                        r_val_wd <= here;
                        r_rc_we  <= 1'b1;
                        r_rc_wd  <= '0;
                        r_lab_wa <= r_s[SW-1:0];
                        r_state  <= r_fin;
                    end else begin
                        r_state <= S_FX_PUT;
                    end
                end
                S_FX_PUT: begin
                    if (can_put) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_FX_RD;
                    end
                end

                // new label: copy the name in, then set up the entry
                S_CP_RD: begin
                    r_state <= (r_i == r_len) ? S_NEW_FIN : S_CP_WR;
                end
                S_CP_WR: begin
                    r_nm_we <= 1'b1;
                    r_nm_wa <= {r_s[SW-1:0], r_i};
                    r_nm_wd <= tok_q;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_CP_RD;
                end
                S_NEW_FIN: begin
                    r_lab_wa <= r_s[SW-1:0];
                    r_len_we <= 1'b1;
                    r_len_wd <= r_len;
                    r_val_we <= 1'b1;
                    r_val_wd <= r_ref ? 16'd0 : here;
                    r_rc_we  <= 1'b1;
                    r_rc_wd  <= r_ref ? RW'(1) : RW'(0);
                    r_lcount <= r_lcount + 1'b1;
                    if (r_ref) begin
                        r_fx_we  <= 1'b1;
                        r_fx_wa  <= {r_s[SW-1:0], RI'(0)};
                        r_fx_wd  <= r_addr;
                        r_e_we   <= 1'b1;
                        r_e_data <= '0;
                        r_e_err  <= tawlf_pkg::ERR_NONE;
                        r_e_slot <= '0;
                        r_ret    <= r_fin;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= r_fin;
                    end
                end

                // unbound label report
                S_REP_RD: begin
                    if (r_cur >= r_lcount || r_ocnt >= OCW'(tawlf_pkg::MAX_RESULTS))
                        r_state <= S_END;
                    else
                        r_state <= S_REP_CHK;
                end
                S_REP_CHK: begin
                    if (val_q != 16'd0 || can_put) begin
                        r_cur   <= r_cur + 1'b1;
                        r_state <= S_REP_RD;
                    end
                end

                // release the held result marked last
                S_END: begin
                    if (!r_pend_v) begin
                        r_state <= S_FETCH;
                    end else if (out_free) begin
                        r_out      <= r_pend;
                        r_out.last <= 1'b1;
                        r_out_v    <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_FETCH;
                    end
                end

                default: r_state <= S_FETCH;
            endcase
        end
    end

    // no result is held back while waiting for the next word
    a_no_pend_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> !r_pend_v)
        else $error("result held across words");

    a_lcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcount <= LW'(NUM_LABELS))
        else $error("label count overflow");

    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= OCW'(tawlf_pkg::MAX_RESULTS))
        else $error("too many results for one word");

    a_tlen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tlen <= NW'(NAME_LEN - 1))
        else $error("token length overflow");

endmodule

// ----- rtl/text_assembler_with_label_fixups.sv -----
// ----------------------------------------------------------------------------
// text_assembler_with_label_fixups
// Streaming assembler: source characters in, 16-bit program writes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_char_code / i_end_of_input and raise push while full
//   is low; one character per word. A four-entry queue decouples the parser.
//   Output queue: while empty is low the oldest result is on the o_ ports; pop
//   takes it. o_last marks the final result caused by one input word.
//   The sequencer finishes each character before it takes the next one.
//   A label lookup walks the table slot by slot, comparing names character by
//   character; a new name is copied in one character at a time.
//   Fixup writes and reported slots are handled one after another.
//   Reset clears the parser, address counter and label count; the label RAMs
//   need no clearing. When the receiver stalls, the sequencer holds at the
//   next result and the input queue fills, then full rises.
// ----------------------------------------------------------------------------
module text_assembler_with_label_fixups #(
    parameter int MEM_WORDS  = 8192,
    parameter int NAME_LEN   = 32,
    parameter int NUM_LABELS = 32,
    parameter int MAX_REFS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic        o_write_enable,
    output logic [12:0] o_write_address,
    output logic [15:0] o_write_data,
    output logic [2:0]  o_error_code,
    output logic [4:0]  o_label_slot,
    output logic        o_last
);

    logic             q_valid;
    logic             q_take;
    tawlf_pkg::t_item q_item;
    tawlf_pkg::t_res  res;

    // parser front and queue
    tawlf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_valid        (q_valid),
        .i_take         (q_take),
        .o_item         (q_item)
    );

    // token sequencer and result stage
    tawlf_back #(
        .MEM_WORDS  (MEM_WORDS),
        .NAME_LEN   (NAME_LEN),
        .NUM_LABELS (NUM_LABELS),
        .MAX_REFS   (MAX_REFS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_take  (q_take),
        .i_item  (q_item),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign o_write_enable  = res.we;
    assign o_write_address = res.addr;
    assign o_write_data    = res.data;
    assign o_error_code    = res.err;
    assign o_label_slot    = res.slot;
    assign o_last          = res.last;

endmodule
